/* design/mtrd_pkg.sv */
// ---------------------------------------------------------------------------
// mtrd_pkg
// Shared types, codes and defaults for the map tile run-length decoder.
// ---------------------------------------------------------------------------
package mtrd_pkg;

  // defaults for the top-level parameters
  localparam int MAP_SIDE_DEF      = 64;
  localparam int QUADRANT_SIDE_DEF = 32;
  localparam int MAX_RUN_DEF       = 256;

  // fixed field widths
  localparam int TILE_W   = 8;
  localparam int DEST_W   = 12;
  localparam int RUN_W    = 9;
  localparam int KIND_W   = 2;
  localparam int FLOOR_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [TILE_W-1:0] ESCAPE_CODE = 8'hFF;

  // most segments one run may give in dungeon mode
  localparam int MAX_SEGS = 5;
  localparam int SEG_CNT_W = $clog2(MAX_SEGS + 1);

  localparam int CMDQ_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd1;

  // map kinds
  localparam logic [KIND_W-1:0] MK_DUNGEON = 2'd2;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_TILE  = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CK_FLAG     = 2'd0,
    CK_OVERFLOW = 2'd1,
    CK_PLAIN    = 2'd2,
    CK_QUAD     = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_WALK  = 2'd2,
    BK_FLUSH = 2'd3
  } bk_state_t;

  // run request handed from the parser to the segment unit
  typedef struct packed {
    cmd_kind_t         kind;
    logic [TILE_W-1:0] tile;
    logic [RUN_W-1:0]  count;
    logic              complete;
    logic              err;
  } cmd_ctl_t;

endpackage

/* design/mtrd_front.sv */
// ---------------------------------------------------------------------------
// mtrd_front
// Byte parser: escape decoding, map position, overflow check and the
// error / completion latches. Emits one request per decoded run or latched-flag byte.
// ---------------------------------------------------------------------------
module mtrd_front import mtrd_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF,
  parameter int MAX_RUN  = MAX_RUN_DEF,
  parameter int PW       = $clog2(MAP_SIDE_DEF * MAP_SIDE_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TILE_W-1:0] in_code_byte,
  input  logic              in_first_byte,
  input  logic [KIND_W-1:0] map_kind,
  output logic              cmd_push,
  input  logic              cmd_room,
  output cmd_ctl_t          cmd_ctl,
  output logic [PW-1:0]     cmd_start
);

  localparam int TOTAL = MAP_SIDE * MAP_SIDE;
  localparam logic [RUN_W-1:0] MAX_RUN_V = RUN_W'(MAX_RUN);

  phase_t            phase_r, phase_nxt;
  logic [TILE_W-1:0] tile_r, tile_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              err_r, err_nxt;
  logic              done_r, done_nxt;

  logic              want_push;
  logic              run_go;
  logic [TILE_W-1:0] run_tile;
  logic [RUN_W-1:0]  run_cnt;
  logic [RUN_W-1:0]  code_ext;
  logic [PW:0]       run_sum;
  logic              accept;

  assign in_ready = cmd_room;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept && want_push;
  assign code_ext = RUN_W'(in_code_byte);

  always_comb begin
    // first byte clears the parser before this byte is decoded
    phase_nxt = in_first_byte ? PH_LEAD : phase_r;
    pos_nxt   = in_first_byte ? '0 : pos_r;
    err_nxt   = in_first_byte ? 1'b0 : err_r;
    done_nxt  = in_first_byte ? 1'b0 : done_r;
    tile_nxt  = tile_r;
    want_push = 1'b0;
    run_go    = 1'b0;
    run_tile  = in_code_byte;
    run_cnt   = RUN_W'(1);
    run_sum   = '0;
    cmd_start = '0;
    cmd_ctl   = '{kind: CK_FLAG, tile: '0, count: '0, complete: done_nxt, err: err_nxt};

    if (err_nxt || done_nxt) begin
      want_push = 1'b1;
    end else begin
      unique case (phase_nxt)
        PH_LEAD: begin
          if (in_code_byte == ESCAPE_CODE) begin
            phase_nxt = PH_TILE;
          end else begin
            run_go = 1'b1;
          end
        end
        PH_TILE: begin
          tile_nxt  = in_code_byte;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          run_go    = 1'b1;
          run_tile  = tile_r;
          phase_nxt = PH_LEAD;
          if (code_ext == '0 || code_ext > MAX_RUN_V) begin
            run_cnt = MAX_RUN_V;
          end else begin
            run_cnt = code_ext;
          end
        end
        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase

      if (run_go) begin
        want_push = 1'b1;
        run_sum   = (PW+1)'(pos_nxt) + (PW+1)'(run_cnt);
        if (run_sum > (PW+1)'(TOTAL)) begin
          err_nxt = 1'b1;
          cmd_ctl = '{kind: CK_OVERFLOW, tile: run_tile, count: '0,
                      complete: 1'b0, err: 1'b1};
        end else begin
          cmd_start = pos_nxt;
          pos_nxt   = PW'(run_sum);
          done_nxt  = (run_sum == (PW+1)'(TOTAL));
          cmd_ctl   = '{kind: (map_kind == MK_DUNGEON) ? CK_QUAD : CK_PLAIN,
                        tile: run_tile, count: run_cnt,
                        complete: done_nxt, err: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      tile_r  <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
      done_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tile_r  <= tile_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      done_r  <= done_nxt;
    end
  end

  // an overflow and a completion can never both be latched
  assert property (@(posedge clk) disable iff (!rst_n) !(err_r && done_r))
    else $error("error and completion latched together");

  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (pos_r == PW'(TOTAL)))
    else $error("completion latched short of the map end");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !want_push) |=> (phase_r != PH_LEAD))
    else $error("byte with no request left the parser at the lead phase");

endmodule

/* design/mtrd_cmd_queue.sv */
// ---------------------------------------------------------------------------
// mtrd_cmd_queue
// Short request queue between the parser and the segment unit.
// ---------------------------------------------------------------------------
module mtrd_cmd_queue import mtrd_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         room,
  input  logic         pop,
  output logic         avail,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(CMDQ_DEPTH);
  localparam int CNTW = $clog2(CMDQ_DEPTH + 1);

  logic [W-1:0]    mem [CMDQ_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign room     = (cnt_r != CNTW'(CMDQ_DEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNTW'(CMDQ_DEPTH))
    else $error("request queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n) !(push && !room))
    else $error("push into a full request queue");

  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !avail))
    else $error("pop from an empty request queue");

endmodule

/* design/mtrd_back.sv */
// ---------------------------------------------------------------------------
// mtrd_back
// Segment unit: turns run requests into result segments. In dungeon mode a
// run is walked one map row per cycle unless the output stalls, clipped to the chosen quadrant.
// ---------------------------------------------------------------------------
module mtrd_back import mtrd_pkg::*; #(
  parameter int MAP_SIDE      = MAP_SIDE_DEF,
  parameter int QUADRANT_SIDE = QUADRANT_SIDE_DEF,
  parameter int PW            = $clog2(MAP_SIDE_DEF * MAP_SIDE_DEF + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_avail,
  output logic               cmd_pop,
  input  cmd_ctl_t           cmd_ctl,
  input  logic [PW-1:0]      cmd_start,
  input  logic [FLOOR_W-1:0] floor_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TILE_W-1:0]  out_tile_value,
  output logic [DEST_W-1:0]  out_dest_start,
  output logic [RUN_W-1:0]   out_run_length,
  output logic               out_last_segment,
  output logic               out_map_complete,
  output logic               out_status
);

  localparam int RW   = $clog2(MAP_SIDE);
  localparam int MW   = PW + 2;
  localparam int PRW  = PW + MW;
  localparam int SHR  = PW + RW;
  // reciprocal for an exact row = pos / MAP_SIDE over every pos below 2**PW
  localparam longint unsigned MAGIC_L = ((64'd1 << SHR) / MAP_SIDE) + 64'd1;
  localparam logic [MW-1:0] MAGIC = MW'(MAGIC_L);
  localparam int CW   = $clog2(MAP_SIDE + 2 * QUADRANT_SIDE + 1);
  localparam int DWR  = RW + $clog2(QUADRANT_SIDE + 1) + 1;
  localparam int DW   = (DWR > DEST_W) ? DWR : DEST_W;
  localparam int WW   = PW + CW;

  bk_state_t bk_state_r, bk_state_nxt;

  logic [TILE_W-1:0]    tile_r;
  logic [PW-1:0]        pos_r, end_r;
  logic                 complete_r;
  logic [PRW-1:0]       prod_r;
  logic [RW-1:0]        row_r;
  logic [CW-1:0]        col_r;
  logic [SEG_CNT_W-1:0] seg_cnt_r;
  logic                 held_v_r;
  logic [DEST_W-1:0]    held_dest_r;
  logic [RUN_W-1:0]     held_len_r;

  logic                 out_valid_r;
  logic [TILE_W-1:0]    out_tile_r;
  logic [DEST_W-1:0]    out_dest_r;
  logic [RUN_W-1:0]     out_len_r;
  logic                 out_last_r, out_done_r, out_status_r;

  logic                 out_free;
  logic                 out_load;
  logic [TILE_W-1:0]    out_tile_nxt;
  logic [DEST_W-1:0]    out_dest_nxt;
  logic [RUN_W-1:0]     out_len_nxt;
  logic                 out_last_nxt, out_done_nxt, out_status_nxt;
  logic                 quad_start, walk_step, flush_emit;

  // row walk datapath
  logic [RW-1:0]  row_div;
  logic [PW-1:0]  rem;
  logic [CW-1:0]  room, c1, lo, hi, off_x, off_y, row_c, step;
  logic [1:0]     quad;
  logic           last_row, in_rows, seg_hit, seg_cap;
  logic [DW-1:0]  dest_w;
  logic [RUN_W-1:0] seg_len;

  assign out_free = !out_valid_r || out_ready;

  assign row_div = prod_r[SHR +: RW];
  assign quad    = floor_number[1:0] - 2'd1;
  assign off_x   = quad[0] ? CW'(QUADRANT_SIDE) : '0;
  assign off_y   = quad[1] ? CW'(QUADRANT_SIDE) : '0;
  assign rem     = end_r - pos_r;
  assign room    = CW'(MAP_SIDE) - col_r;
  assign last_row = WW'(rem) <= WW'(room);
  assign c1      = last_row ? (col_r + CW'(rem)) : CW'(MAP_SIDE);
  assign lo      = (col_r < off_x) ? off_x : col_r;
  assign hi      = (c1 > off_x + CW'(QUADRANT_SIDE)) ? (off_x + CW'(QUADRANT_SIDE)) : c1;
  assign row_c   = CW'(row_r);
  assign in_rows = (row_c >= off_y) && (row_c < off_y + CW'(QUADRANT_SIDE));
  assign seg_hit = in_rows && (lo < hi);
  assign seg_len = RUN_W'(hi - lo);
  assign dest_w  = DW'(row_c - off_y) * DW'(QUADRANT_SIDE) + DW'(lo - off_x);
  assign step    = c1 - col_r;
  assign seg_cap = (seg_cnt_r + SEG_CNT_W'(1)) == SEG_CNT_W'(MAX_SEGS);

  // next state
  always_comb begin
    bk_state_nxt = bk_state_r;
    unique case (bk_state_r)
      BK_IDLE: begin
        if (cmd_avail && cmd_ctl.kind == CK_QUAD) begin
          bk_state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        bk_state_nxt = BK_WALK;
      end
      BK_WALK: begin
        if (walk_step && (last_row || (seg_hit && seg_cap))) begin
          bk_state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!(held_v_r || complete_r) || out_free) begin
          bk_state_nxt = BK_IDLE;
        end
      end
      default: begin
        bk_state_nxt = BK_IDLE;
      end
    endcase
  end

  // control and result selection
  always_comb begin
    cmd_pop        = 1'b0;
    quad_start     = 1'b0;
    walk_step      = 1'b0;
    flush_emit     = 1'b0;
    out_load       = 1'b0;
    out_tile_nxt   = tile_r;
    out_dest_nxt   = held_dest_r;
    out_len_nxt    = held_len_r;
    out_last_nxt   = 1'b0;
    out_done_nxt   = 1'b0;
    out_status_nxt = 1'b0;
    unique case (bk_state_r)
      BK_IDLE: begin
        if (cmd_avail) begin
          if (cmd_ctl.kind == CK_QUAD) begin
            cmd_pop    = 1'b1;
            quad_start = 1'b1;
          end else if (out_free) begin
            cmd_pop        = 1'b1;
            out_load       = 1'b1;
            out_tile_nxt   = cmd_ctl.tile;
            out_dest_nxt   = DEST_W'(cmd_start);
            out_len_nxt    = cmd_ctl.count;
            out_last_nxt   = 1'b1;
            out_done_nxt   = cmd_ctl.complete;
            out_status_nxt = cmd_ctl.err;
          end
        end
      end
      BK_DIV: begin
      end
      BK_WALK: begin
        // a new segment pushes the held one out, so it needs a free output
        walk_step = !(seg_hit && held_v_r && !out_free);
        out_load  = walk_step && seg_hit && held_v_r;
      end
      BK_FLUSH: begin
        flush_emit   = (held_v_r || complete_r) && out_free;
        out_load     = flush_emit;
        out_last_nxt = 1'b1;
        out_done_nxt = complete_r;
        if (!held_v_r) begin
          out_dest_nxt = '0;
          out_len_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r  <= BK_IDLE;
      held_v_r    <= 1'b0;
      seg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bk_state_r <= bk_state_nxt;
      if (quad_start) begin
        held_v_r  <= 1'b0;
        seg_cnt_r <= '0;
      end else if (walk_step && seg_hit) begin
        held_v_r  <= 1'b1;
        seg_cnt_r <= seg_cnt_r + SEG_CNT_W'(1);
      end else if (bk_state_r == BK_FLUSH && bk_state_nxt == BK_IDLE) begin
        held_v_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_start) begin
      tile_r     <= cmd_ctl.tile;
      pos_r      <= cmd_start;
      end_r      <= cmd_start + PW'(cmd_ctl.count);
      complete_r <= cmd_ctl.complete;
      prod_r     <= PRW'(cmd_start) * PRW'(MAGIC);
    end
    if (bk_state_r == BK_DIV) begin
      row_r <= row_div;
      col_r <= CW'(pos_r - PW'(row_div * PW'(MAP_SIDE)));
    end
    if (walk_step) begin
      pos_r <= pos_r + PW'(step);
      row_r <= row_r + RW'(1);
      col_r <= '0;
      if (seg_hit) begin
        held_dest_r <= DEST_W'(dest_w);
        held_len_r  <= seg_len;
      end
    end
    if (out_load) begin
      out_tile_r   <= out_tile_nxt;
      out_dest_r   <= out_dest_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
      out_done_r   <= out_done_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tile_value   = out_tile_r;
  assign out_dest_start   = out_dest_r;
  assign out_run_length   = out_len_r;
  assign out_last_segment = out_last_r;
  assign out_map_complete = out_done_r;
  assign out_status       = out_status_r;

  assert property (@(posedge clk) disable iff (!rst_n) seg_cnt_r <= SEG_CNT_W'(MAX_SEGS))
    else $error("segment count above limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_WALK) |-> (pos_r < end_r))
    else $error("row walk past the end of the run");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_len_r == '0) |-> out_last_r)
    else $error("empty segment not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_IDLE) |-> !held_v_r)
    else $error("held segment left over after a run");

endmodule

/* design/map_tile_rle_decoder.sv */
// Outside dungeon mode a literal or count byte's result passes the request queue, then the output register.
// Throughput: one byte per cycle outside dungeon mode while the queue has room, escape and tile bytes included.
// Dungeon runs: the segment unit takes each run through idle, divide, walk and flush states (one map row per
// walk cycle unless the output stalls), and the two-entry request queue lets the parser run ahead meanwhile.
// Reset (synchronous, rst_n low): parser, latches, queue and output cleared, map kind town,
// floor 1; no clearing pass.
// ---------------------------------------------------------------------------
// map_tile_rle_decoder
// Escape-byte run-length decoder for a square tile map, with optional
// quadrant extraction for dungeon maps.
// ---------------------------------------------------------------------------
module map_tile_rle_decoder import mtrd_pkg::*; #(
  parameter int MAP_SIDE      = MAP_SIDE_DEF,
  parameter int QUADRANT_SIDE = QUADRANT_SIDE_DEF,
  parameter int MAX_RUN       = MAX_RUN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TILE_W-1:0]     in_code_byte,
  input  logic                  in_first_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TILE_W-1:0]     out_tile_value,
  output logic [DEST_W-1:0]     out_dest_start,
  output logic [RUN_W-1:0]      out_run_length,
  output logic                  out_last_segment,
  output logic                  out_map_complete,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = $clog2(MAP_SIDE * MAP_SIDE + 1);
  localparam int QW = $bits(cmd_ctl_t) + PW;

  logic [KIND_W-1:0]  map_kind_r;
  logic [FLOOR_W-1:0] floor_r;

  logic          push, room, pop, avail;
  cmd_ctl_t      push_ctl, pop_ctl;
  logic [PW-1:0] push_start, pop_start;
  logic [QW-1:0] push_word, pop_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_kind_r <= '0;
      floor_r    <= FLOOR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAP_KIND: map_kind_r <= cfg_data[KIND_W-1:0];
        CFG_FLOOR:    floor_r    <= cfg_data[FLOOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mtrd_front #(
    .MAP_SIDE (MAP_SIDE),
    .MAX_RUN  (MAX_RUN),
    .PW       (PW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_byte  (in_code_byte),
    .in_first_byte (in_first_byte),
    .map_kind      (map_kind_r),
    .cmd_push      (push),
    .cmd_room      (room),
    .cmd_ctl       (push_ctl),
    .cmd_start     (push_start)
  );

  assign push_word = {push_ctl, push_start};
  assign {pop_ctl, pop_start} = pop_word;

  mtrd_cmd_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .room      (room),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_word)
  );

  mtrd_back #(
    .MAP_SIDE      (MAP_SIDE),
    .QUADRANT_SIDE (QUADRANT_SIDE),
    .PW            (PW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_avail        (avail),
    .cmd_pop          (pop),
    .cmd_ctl          (pop_ctl),
    .cmd_start        (pop_start),
    .floor_number     (floor_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_value   (out_tile_value),
    .out_dest_start   (out_dest_start),
    .out_run_length   (out_run_length),
    .out_last_segment (out_last_segment),
    .out_map_complete (out_map_complete),
    .out_status       (out_status)
  );

endmodule

/* dv/map_tile_rle_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// map_tile_rle_checker
// Watches the byte, segment and register channels of the decoder, keeps its
// own copy of the parser state and registers, works out the segments each
// accepted byte must give and compares them in order with the ones that come.
// ---------------------------------------------------------------------------
module map_tile_rle_checker import mtrd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TILE_W-1:0]     in_code_byte,
  input  logic                  in_first_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [TILE_W-1:0]     out_tile_value,
  input  logic [DEST_W-1:0]     out_dest_start,
  input  logic [RUN_W-1:0]      out_run_length,
  input  logic                  out_last_segment,
  input  logic                  out_map_complete,
  input  logic                  out_status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [KIND_W-1:0]  MK_TOWN     = 2'd0;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 5'd1;
  localparam int MAP_TILES = MAP_SIDE_DEF * MAP_SIDE_DEF;
  localparam int QS        = QUADRANT_SIDE_DEF;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic [DEST_W-1:0] dest;
    logic [RUN_W-1:0]  len;
    logic              last;
    logic              complete;
    logic              status;
  } seg_t;

  seg_t segs_due[$];

  // decoder state and registers
  logic [KIND_W-1:0]  kind_q;
  logic [FLOOR_W-1:0] floor_q;
  phase_t             phase_q;
  logic [TILE_W-1:0]  held_tile;
  logic [12:0]        src_pos;
  logic               err_flag;
  logic               done_flag;

  int n_fail = 0;
  assign fail_count = n_fail;

  task automatic report_mismatch(input string msg);
    n_fail++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic add_due(input seg_t s);
    segs_due = {segs_due, s};
  endtask

  function automatic seg_t make_seg(input int unsigned tile, input int unsigned dest,
                                    input int unsigned len, input logic last,
                                    input logic complete, input logic status);
    seg_t r;
    r.tile     = tile[TILE_W-1:0];
    r.dest     = dest[DEST_W-1:0];
    r.len      = len[RUN_W-1:0];
    r.last     = last;
    r.complete = complete;
    r.status   = status;
    return r;
  endfunction

  // segments caused by one accepted byte
  task automatic decode_code_byte(input logic [TILE_W-1:0] code, input logic first);
    int unsigned tile, count, start, stop, quad, ox, oy;
    int unsigned s, row, rbase, e, c0, c1;
    logic        complete;
    seg_t        segs [MAX_SEGS];
    int          n;
    if (first) begin
      src_pos   = '0;
      phase_q   = PH_LEAD;
      err_flag  = 1'b0;
      done_flag = 1'b0;
    end
    if (err_flag || done_flag) begin
      add_due(make_seg(0, 0, 0, 1'b1, done_flag, err_flag));
      return;
    end
    case (phase_q)
      PH_LEAD: begin
        if (code == ESCAPE_CODE) begin
          phase_q = PH_TILE;
          return;
        end
        tile  = code;
        count = 1;
      end
      PH_TILE: begin
        held_tile = code;
        phase_q   = PH_COUNT;
        return;
      end
      default: begin
        tile  = held_tile;
        count = (code == 0) ? MAX_RUN_DEF : code;
        if (count > MAX_RUN_DEF) count = MAX_RUN_DEF;
        phase_q = PH_LEAD;
      end
    endcase

    if (src_pos + count > MAP_TILES) begin
      err_flag = 1'b1;
      add_due(make_seg(tile, 0, 0, 1'b1, 1'b0, 1'b1));
      return;
    end
    start    = src_pos;
    stop     = start + count;
    src_pos  = stop[12:0];
    complete = (stop == MAP_TILES);
    if (complete) done_flag = 1'b1;

    if (kind_q != MK_DUNGEON) begin
      add_due(make_seg(tile, start, count, 1'b1, complete, 1'b0));
      return;
    end

    // split at map rows and clip to the chosen quadrant
    quad = (floor_q - 1) & 3;
    ox   = quad[0] * QS;
    oy   = quad[1] * QS;
    s    = start;
    n    = 0;
    while (s < stop && n < MAX_SEGS) begin
      row   = s / MAP_SIDE_DEF;
      rbase = row * MAP_SIDE_DEF;
      e     = rbase + MAP_SIDE_DEF;
      if (e > stop) e = stop;
      c0 = s - rbase;
      c1 = e - rbase;
      if (c0 < ox) c0 = ox;
      if (c1 > ox + QS) c1 = ox + QS;
      if (row >= oy && row < oy + QS && c0 < c1) begin
        segs[n] = make_seg(tile, (row - oy) * QS + (c0 - ox), c1 - c0, 1'b0, 1'b0, 1'b0);
        n++;
      end
      s = e;
    end
    if (n == 0) begin
      if (!complete) return;
      // run fell outside the quadrant but still finished the map
      segs[0] = make_seg(tile, 0, 0, 1'b0, 1'b0, 1'b0);
      n = 1;
    end
    segs[n-1].last     = 1'b1;
    segs[n-1].complete = complete;
    for (int k = 0; k < n; k++) add_due(segs[k]);
  endtask

  task automatic check_segment();
    seg_t got, want;
    got = {out_tile_value, out_dest_start, out_run_length,
           out_last_segment, out_map_complete, out_status};
    if (segs_due.size() == 0) begin
      report_mismatch($sformatf("segment with none due: tile %0d dest %0d len %0d",
                                got.tile, got.dest, got.len));
      return;
    end
    want = segs_due.pop_front();
    if (got.tile != want.tile)
      report_mismatch($sformatf("tile_value %0d, want %0d", got.tile, want.tile));
    if (got.dest != want.dest)
      report_mismatch($sformatf("dest_start %0d, want %0d", got.dest, want.dest));
    if (got.len != want.len)
      report_mismatch($sformatf("run_length %0d, want %0d", got.len, want.len));
    if (got.last != want.last)
      report_mismatch($sformatf("last_segment %0b, want %0b", got.last, want.last));
    if (got.complete != want.complete)
      report_mismatch($sformatf("map_complete %0b, want %0b", got.complete, want.complete));
    if (got.status != want.status)
      report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kind_q    = MK_TOWN;
      floor_q   = FLOOR_RESET;
      phase_q   = PH_LEAD;
      held_tile = '0;
      src_pos   = '0;
      err_flag  = 1'b0;
      done_flag = 1'b0;
      segs_due.delete();
    end else begin
      if (out_valid && out_ready) check_segment();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_KIND) kind_q = cfg_data[KIND_W-1:0];
        else if (cfg_index == CFG_FLOOR) floor_q = cfg_data[FLOOR_W-1:0];
      end
      if (in_valid && in_ready) decode_code_byte(in_code_byte, in_first_byte);
    end
    pending = segs_due.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives compressed map bytes and register writes into the run-length
// decoder with random gaps and back-pressure: a directed opening in town and
// dungeon mode, then whole, overflowing and short maps under fixed and random settings. The
// checker beside the block judges every segment.
// ---------------------------------------------------------------------------
module tb_top;
  import mtrd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;
  localparam int MAP_TILES  = MAP_SIDE_DEF * MAP_SIDE_DEF;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 10;
  localparam int WDOG_LIMIT = 5000;
  localparam int N_DIRECTED = 26;
  localparam int N_RANDOM   = 160;

  // how a random map ends
  localparam int END_FULL     = 0;
  localparam int END_OVERFLOW = 1;
  localparam int END_SHORT    = 2;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [TILE_W-1:0]     in_code_byte;
  logic                  in_first_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [TILE_W-1:0]     out_tile_value;
  logic [DEST_W-1:0]     out_dest_start;
  logic [RUN_W-1:0]      out_run_length;
  logic                  out_last_segment;
  logic                  out_map_complete;
  logic                  out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int n_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  map_tile_rle_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_value   (out_tile_value),
    .out_dest_start   (out_dest_start),
    .out_run_length   (out_run_length),
    .out_last_segment (out_last_segment),
    .out_map_complete (out_map_complete),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  map_tile_rle_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_value   (out_tile_value),
    .out_dest_start   (out_dest_start),
    .out_run_length   (out_run_length),
    .out_last_segment (out_last_segment),
    .out_map_complete (out_map_complete),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // segment receiver with random back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // leaves valid high after the request; the next call takes it over or drain() lowers it
  task automatic send_byte(input logic [TILE_W-1:0] code, input logic first);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_code_byte  <= code;
    in_first_byte <= first;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // wait for every due segment, then let the segment unit finish
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] kind_data,
                            input logic [CFG_DATA_W-1:0] floor_data);
    drain();
    cfg_write(CFG_MAP_KIND, kind_data);
    cfg_write(CFG_FLOOR, floor_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_run(input logic [TILE_W-1:0] tile, input int count, input logic first);
    logic [TILE_W-1:0] count_byte;
    count_byte = count[TILE_W-1:0];  // a full run of 256 is coded as 0
    send_byte(ESCAPE_CODE, first);
    send_byte(tile, 1'b0);
    send_byte(count_byte, 1'b0);
  endtask

  // one map: well-formed runs with a little noise, ending as the mode says
  task automatic run_map(input int mode);
    int  rem, budget, count, r, trail;
    bit  first, stop;
    rem    = MAP_TILES;
    budget = $urandom_range(10, 40);
    first  = 1'b1;
    stop   = 1'b0;
    while (!stop) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_byte(8'($urandom_range(0, 255)), first || ($urandom_range(0, 15) == 0));
        budget--;
      end else if (r < 20) begin
        send_byte(8'($urandom_range(0, 254)), first);
        rem--;
        budget--;
      end else begin
        if (rem <= MAX_RUN_DEF) begin
          if (mode == END_FULL)
            count = (rem > QUADRANT_SIDE_DEF && $urandom_range(0, 1)) ?
                    rem - $urandom_range(1, QUADRANT_SIDE_DEF) : rem;
          else if (mode == END_OVERFLOW && rem < MAX_RUN_DEF)
            count = $urandom_range(rem + 1, MAX_RUN_DEF);
          else
            count = $urandom_range(1, rem);
        end else begin
          count = $urandom_range(0, 2) ? MAX_RUN_DEF : $urandom_range(1, MAX_RUN_DEF - 1);
        end
        send_run(8'($urandom_range(0, 255)), count, first);
        budget -= 3;
        rem    -= count;
      end
      first = 1'b0;
      if (rem <= 0) begin
        // map done or overflowed: a few bytes hit the latched flags
        trail = $urandom_range(1, 3);
        repeat (trail) send_byte(8'($urandom_range(0, 255)), 1'b0);
        stop = 1'b1;
      end else if (mode == END_SHORT && budget <= 0) begin
        stop = 1'b1;
      end
    end
  endtask

  initial begin
    int sess;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_code_byte  = '0;
    in_first_byte = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_MAP_KIND;
    cfg_data      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // town mode after reset: literals, full and near-full runs, escape as tile
    send_byte(8'h00, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_run(8'hFF, MAX_RUN_DEF, 1'b0);
    send_run(8'hAA, 255, 1'b0);
    // new map marked on what would have been the tile byte
    send_byte(ESCAPE_CODE, 1'b0);
    send_byte(8'h33, 1'b1);

    // dungeon, upper-left quadrant; unused register indexes are ignored
    drain();
    cfg_write(CFG_NONE, 8'hFF);
    cfg_write(CFG_SPARE, 8'hFF);
    cfg_write(CFG_MAP_KIND, CFG_DATA_W'(MK_DUNGEON));
    cfg_write(CFG_FLOOR, 8'd1);
    cfg_valid <= 1'b0;
    send_run(8'h5A, MAX_RUN_DEF, 1'b1);
    send_run(8'h11, 180, 1'b0);
    send_byte(8'h77, 1'b0);              // right half, nothing kept
    send_run(8'h01, MAX_RUN_DEF, 1'b0);
    send_run(8'h80, 21, 1'b0);           // right half of one row, then the left of the next
    send_run(8'h02, MAX_RUN_DEF, 1'b0);  // five segments

    sess = 0;
    while (n_sent < N_DIRECTED + N_RANDOM) begin
      if (sess == 0)
        set_config(CFG_DATA_W'(MK_DUNGEON), 8'd16);
      else if (sess == 1)
        set_config(8'hFF, 8'h00);
      else
        set_config({6'($urandom_range(0, 63)),
                    $urandom_range(0, 1) ? MK_DUNGEON : 2'($urandom_range(0, 3))},
                   $urandom_range(0, 3) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(0, 255)));
      quiet = ($urandom_range(0, 3) == 0);
      run_map(sess % 3);
      sess++;
    end
    quiet = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
